// ===== rtl/core/b2r_pkg.sv =====
package b2r_pkg;

    localparam int HEADER_BYTES   = 54;
    localparam int WIDTH_OFFSET   = 18;
    localparam int HEIGHT_OFFSET  = 22;
    localparam int SIZE_BYTES     = 4;
    localparam int HDR_CNT_W      = 6;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int DIM_W          = 13;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_ENABLE = 2'd0,
        REG_KEY_RED    = 2'd1,
        REG_KEY_GREEN  = 2'd2,
        REG_KEY_BLUE   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2
    } phase_t;

    typedef struct packed {
        logic             enable;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } key_t;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             last_pixel;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } pix_t;

    typedef struct packed {
        logic                               full;
        logic                               empty;
        logic [$clog2(QUEUE_DEPTH+1)-1:0]   count;
    } q_stat_t;

endpackage

// ===== rtl/core/b2r_if.sv =====
interface b2r_byte_if;
    import b2r_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       start_of_file;

    modport source (output valid, output file_byte, output start_of_file, input ready);
    modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

interface b2r_pix_if;
    import b2r_pkg::*;

    logic             valid;
    logic             ready;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             last_pixel;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output last_pixel, output image_width, output image_height,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input last_pixel, input image_width, input image_height,
                    output ready);
endinterface

interface b2r_cfg_if;
    import b2r_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bmp24_to_rgba_color_key.sv =====
// channel  | dir | payload                                    | request
// ---------+-----+--------------------------------------------+---------------------
// bytes    | in  | file_byte, start_of_file                   | one file byte
// pixels   | out | red, green, blue, alpha, last_pixel, dims  | one RGBA pixel
// cfg      | in  | index, data                                | one key register write
//
// One byte per cycle while ready; pixels go via the queue to the output register.
// A two-entry queue sits between the byte parser and the output register;
// bytes.ready drops only while that queue is full. cfg.ready is always high.
// rst_n clears the parser, the queue and the key registers; no clearing pass.
module bmp24_to_rgba_color_key #(
    parameter int MAX_WIDTH  = b2r_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = b2r_pkg::DEF_MAX_HEIGHT
) (
    input  logic       clk,
    input  logic       rst_n,
    b2r_byte_if.sink   bytes,
    b2r_pix_if.source  pixels,
    b2r_cfg_if.sink    cfg
);
    import b2r_pkg::*;

    key_t    key_reg, key_next;
    q_stat_t q_stat;
    pix_t    push_pix;
    pix_t    head;
    logic    push;
    logic    pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        key_next = key_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_KEY_ENABLE: key_next.enable = cfg.data[0];
                REG_KEY_RED:    key_next.red    = cfg.data;
                REG_KEY_GREEN:  key_next.green  = cfg.data;
                REG_KEY_BLUE:   key_next.blue   = cfg.data;
                default:        key_next        = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    b2r_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes    (bytes),
        .q_stat   (q_stat),
        .push     (push),
        .push_pix (push_pix)
    );

    b2r_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pix (push_pix),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    b2r_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head),
        .key    (key_reg),
        .pop    (pop),
        .pixels (pixels)
    );

    a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid |-> (pixels.alpha == ALPHA_CLEAR || pixels.alpha == ALPHA_OPAQUE))
        else $error("alpha neither clear nor opaque");

    a_clear_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        (pixels.valid && pixels.alpha == ALPHA_CLEAR) |-> key_reg.enable)
        else $error("transparent pixel while key disabled");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= $bits(q_stat.count)'(QUEUE_DEPTH))
        else $error("pixel queue overfilled");

    a_queue_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
        else $error("queue count lost a push");

endmodule

// ===== rtl/core/b2r_front.sv =====
module b2r_front #(
    parameter int MAX_WIDTH  = b2r_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = b2r_pkg::DEF_MAX_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    b2r_byte_if.sink          bytes,
    input  b2r_pkg::q_stat_t  q_stat,
    output logic              push,
    output b2r_pkg::pix_t     push_pix
);
    import b2r_pkg::*;

    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
    localparam int RBC_W    = $clog2(3 * MAX_WIDTH + 4);

    logic [HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next, c_hdr;
    logic [31:0]          width_reg, width_next, c_width;
    logic [31:0]          height_reg, height_next, c_height;
    logic [RBC_W-1:0]     row_pix_reg, row_pix_next;
    logic [RBC_W-1:0]     stride_reg, stride_next;
    logic [RBC_W-1:0]     rbc_reg, rbc_next, c_rbc, rbc_inc;
    logic [HEIGHT_W-1:0]  row_cnt_reg, row_cnt_next, c_row, hgt;
    logic [15:0]          held_reg, held_next, c_held;
    phase_t               phase_reg, phase_next, c_phase;
    logic                 bad_reg, bad_next, c_bad;
    logic                 accept, sof;
    logic [1:0]           lane;
    logic [RBC_W-1:0]     w_ext;

    assign bytes.ready = !q_stat.full;
    assign accept      = bytes.valid && bytes.ready;
    assign sof         = bytes.start_of_file;

    // start of file clears the parse state before the byte is used
    assign c_hdr    = sof ? '0 : hdr_cnt_reg;
    assign c_width  = sof ? '0 : width_reg;
    assign c_height = sof ? '0 : height_reg;
    assign c_rbc    = sof ? '0 : rbc_reg;
    assign c_row    = sof ? '0 : row_cnt_reg;
    assign c_held   = sof ? '0 : held_reg;
    assign c_phase  = sof ? PH_BLUE : phase_reg;
    assign c_bad    = sof ? 1'b0 : bad_reg;

    assign hgt     = c_height[HEIGHT_W-1:0];
    assign rbc_inc = c_rbc + RBC_W'(1);
    assign w_ext   = RBC_W'(c_width[WIDTH_W-1:0]);

    always_comb
    begin
        hdr_cnt_next = hdr_cnt_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        row_pix_next = row_pix_reg;
        stride_next  = stride_reg;
        rbc_next     = rbc_reg;
        row_cnt_next = row_cnt_reg;
        held_next    = held_reg;
        phase_next   = phase_reg;
        bad_next     = bad_reg;
        lane         = '0;
        push         = 1'b0;

        push_pix.red          = bytes.file_byte;
        push_pix.green        = c_held[15:8];
        push_pix.blue         = c_held[7:0];
        push_pix.last_pixel   = (c_row + HEIGHT_W'(1) == hgt) && (rbc_inc == row_pix_reg);
        push_pix.image_width  = c_width[DIM_W-1:0];
        push_pix.image_height = c_height[DIM_W-1:0];

        if (accept)
        begin
            hdr_cnt_next = c_hdr;
            width_next   = c_width;
            height_next  = c_height;
            rbc_next     = c_rbc;
            row_cnt_next = c_row;
            held_next    = c_held;
            phase_next   = c_phase;
            bad_next     = c_bad;

            if (c_hdr < HDR_CNT_W'(HEADER_BYTES))
            begin
                if (c_hdr >= HDR_CNT_W'(WIDTH_OFFSET) &&
                    c_hdr < HDR_CNT_W'(WIDTH_OFFSET + SIZE_BYTES))
                begin
                    lane = 2'(c_hdr - HDR_CNT_W'(WIDTH_OFFSET));
                    width_next[{lane, 3'b000} +: 8] = bytes.file_byte;
                end
                else if (c_hdr >= HDR_CNT_W'(HEIGHT_OFFSET) &&
                         c_hdr < HDR_CNT_W'(HEIGHT_OFFSET + SIZE_BYTES))
                begin
                    lane = 2'(c_hdr - HDR_CNT_W'(HEIGHT_OFFSET));
                    height_next[{lane, 3'b000} +: 8] = bytes.file_byte;
                end
                hdr_cnt_next = c_hdr + HDR_CNT_W'(1);
                // row geometry settles long before the header ends
                row_pix_next = (w_ext << 1) + w_ext;
                stride_next  = ((w_ext << 1) + w_ext + RBC_W'(3)) & ~RBC_W'(3);
                if (hdr_cnt_next == HDR_CNT_W'(HEADER_BYTES))
                begin
                    bad_next = (width_next > 32'(MAX_WIDTH)) ||
                               (height_next > 32'(MAX_HEIGHT));
                end
            end
            else if (!c_bad && c_width != 32'd0 && c_row < hgt)
            begin
                if (c_rbc < row_pix_reg)
                begin
                    case (c_phase)
                        PH_BLUE:
                        begin
                            held_next[7:0] = bytes.file_byte;
                            phase_next     = PH_GREEN;
                        end
                        PH_GREEN:
                        begin
                            held_next[15:8] = bytes.file_byte;
                            phase_next      = PH_RED;
                        end
                        default:
                        begin
                            push       = 1'b1;
                            phase_next = PH_BLUE;
                        end
                    endcase
                end
                rbc_next = rbc_inc;
                if (rbc_inc >= stride_reg)
                begin
                    rbc_next     = '0;
                    row_cnt_next = c_row + HEIGHT_W'(1);
                    phase_next   = PH_BLUE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            row_pix_reg <= '0;
            stride_reg  <= '0;
            rbc_reg     <= '0;
            row_cnt_reg <= '0;
            held_reg    <= '0;
            phase_reg   <= PH_BLUE;
            bad_reg     <= 1'b0;
        end
        else
        begin
            hdr_cnt_reg <= hdr_cnt_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            row_pix_reg <= row_pix_next;
            stride_reg  <= stride_next;
            rbc_reg     <= rbc_next;
            row_cnt_reg <= row_cnt_next;
            held_reg    <= held_next;
            phase_reg   <= phase_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

// ===== rtl/core/b2r_queue.sv =====
module b2r_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b2r_pkg::pix_t     push_pix,
    input  logic              pop,
    output b2r_pkg::pix_t     head,
    output b2r_pkg::q_stat_t  q_stat
);
    import b2r_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pix_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.count = count_reg;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/b2r_back.sv =====
module b2r_back (
    input  logic              clk,
    input  logic              rst_n,
    input  b2r_pkg::q_stat_t  q_stat,
    input  b2r_pkg::pix_t     head,
    input  b2r_pkg::key_t     key,
    output logic              pop,
    b2r_pix_if.source         pixels
);
    import b2r_pkg::*;

    logic       out_valid_reg, out_valid_next;
    pix_t       out_pix_reg;
    logic [7:0] out_alpha_reg;
    logic       key_hit;

    assign pop     = !q_stat.empty && (!out_valid_reg || pixels.ready);
    assign key_hit = key.enable && head.red == key.red &&
                     head.green == key.green && head.blue == key.blue;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixels.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_pix_reg   <= head;
            out_alpha_reg <= key_hit ? ALPHA_CLEAR : ALPHA_OPAQUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign pixels.valid        = out_valid_reg;
    assign pixels.red          = out_pix_reg.red;
    assign pixels.green        = out_pix_reg.green;
    assign pixels.blue         = out_pix_reg.blue;
    assign pixels.alpha        = out_alpha_reg;
    assign pixels.last_pixel   = out_pix_reg.last_pixel;
    assign pixels.image_width  = out_pix_reg.image_width;
    assign pixels.image_height = out_pix_reg.image_height;

endmodule
